// ===== rtl/cqps_pkg.sv =====
package cqps_pkg;

  localparam logic [1:0] CMD_ENQ       = 2'd0;
  localparam logic [1:0] CMD_DEQ_CLASS = 2'd1;
  localparam logic [1:0] CMD_DEQ_SCHED = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_EMPTY    = 2'd2;
  localparam logic [1:0] STAT_BADCLASS = 2'd3;

  localparam logic [1:0] MODE_HIGH_FIRST = 2'd0;
  localparam logic [1:0] MODE_LOW_FIRST  = 2'd1;

  localparam logic [1:0] CFG_SCHED_MODE    = 2'd0;
  localparam logic [1:0] CFG_DEFAULT_CLASS = 2'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  tclass;
    logic [31:0] pkt_handle;
    logic [15:0] pkt_len;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_handle;
    logic [15:0] out_len;
    logic [2:0]  served_class;
    logic [31:0] dropped_total;
    logic [31:0] queued_packets_total;
    logic [47:0] queued_bytes_total;
    logic [31:0] sent_packets_total;
    logic [47:0] sent_bytes_total;
  } out_word_t;

  typedef struct packed {
    logic [31:0] handle;
    logic [15:0] len;
  } entry_t;

endpackage

// ===== rtl/class_queue_priority_scheduler.sv =====
// Strict-priority packet descriptor queues: one ring FIFO per traffic class, all classes
// sharing one descriptor RAM (handle and length) addressed by {class, pointer}. An accepted
// word goes into the request register; in S_EXEC an enqueue or a failed dequeue registers
// its result, while a successful dequeue does a registered read of the descriptor RAM and
// registers its result in S_READ. One word is in work at a time; the next word is taken
// once the result is in the output register, so a stalled output holds the input. In the
// high-first and low-first modes the scheduler pick is a priority encoder over per-class
// non-empty flags. No clearing pass: the block is ready right after reset.
module class_queue_priority_scheduler
  import cqps_pkg::*;
#(
  parameter int NUM_CLASSES = 8,
  parameter int QUEUE_DEPTH = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [2:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W  = CLS_W + PTR_W;
  localparam int MEM_DEPTH = NUM_CLASSES << PTR_W;
  localparam logic [4:0]       NUM_CLS5 = 5'(NUM_CLASSES);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  state_e state_q, state_d;

  logic [1:0] mode_q;
  logic [2:0] dflt_q;

  in_word_t req_q;

  logic [PTR_W-1:0] rptr_q [NUM_CLASSES];
  logic [PTR_W-1:0] rptr_d [NUM_CLASSES];
  logic [PTR_W-1:0] wptr_q [NUM_CLASSES];
  logic [PTR_W-1:0] wptr_d [NUM_CLASSES];
  logic [CNT_W-1:0] cnt_q  [NUM_CLASSES];
  logic [CNT_W-1:0] cnt_d  [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] nonempty;

  logic [31:0] drop_q, drop_d;
  logic [31:0] enq_pkts_q, enq_pkts_d;
  logic [47:0] enq_bytes_q, enq_bytes_d;
  logic [31:0] sent_pkts_q, sent_pkts_d;
  logic [47:0] sent_bytes_q, sent_bytes_d;

  logic [2:0] srv_q, srv_d;

  logic      out_valid_q;
  out_word_t out_q, out_d;
  logic      out_free;

  entry_t mem [MEM_DEPTH];
  entry_t rd_q;
  logic   mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;

  logic exec_commit, exec_load, read_load;

  logic [3:0] sched_lo, sched_hi, enq_cls4, tgt4;
  logic       sched_hit, tgt_ok, op_enq, op_deq, miss, do_pop, full;
  logic [CLS_W-1:0] tgt;

  always_comb begin
    for (int k = 0; k < NUM_CLASSES; k++) begin
      nonempty[k] = (cnt_q[k] != '0);
    end
  end

  always_comb begin
    sched_lo  = '0;
    sched_hi  = '0;
    sched_hit = 1'b0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (nonempty[k] && !sched_hit) begin
        sched_lo = 4'(k);
      end
      if (nonempty[k]) begin
        sched_hi  = 4'(k);
        sched_hit = 1'b1;
      end
    end
  end

  always_comb begin
    enq_cls4 = (5'(req_q.tclass) < NUM_CLS5) ? req_q.tclass : {1'b0, dflt_q};
    tgt4   = '0;
    op_enq = 1'b0;
    op_deq = 1'b0;
    miss   = 1'b0;
    unique case (req_q.cmd)
      CMD_ENQ: begin
        tgt4   = enq_cls4;
        op_enq = 1'b1;
      end
      CMD_DEQ_CLASS: begin
        tgt4   = req_q.tclass;
        op_deq = 1'b1;
      end
      CMD_DEQ_SCHED: begin
        op_deq = 1'b1;
        if (mode_q == MODE_HIGH_FIRST || mode_q == MODE_LOW_FIRST) begin
          tgt4 = (mode_q == MODE_HIGH_FIRST) ? sched_hi : sched_lo;
          miss = !sched_hit;
        end else begin
          tgt4 = {1'b0, dflt_q};
        end
      end
      default: begin
        miss = 1'b1;
      end
    endcase
    tgt_ok = (5'(tgt4) < NUM_CLS5);
    tgt    = tgt4[CLS_W-1:0];
    full   = (cnt_q[tgt] == CNT_FULL);
    do_pop = op_deq && !miss && tgt_ok && nonempty[tgt];
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (do_pop) begin
          state_d = S_READ;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    exec_commit = 1'b0;
    exec_load   = 1'b0;
    read_load   = 1'b0;
    unique case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_EXEC: begin
        exec_commit = do_pop || out_free;
        exec_load   = !do_pop && out_free;
      end
      S_READ: read_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    rptr_d       = rptr_q;
    wptr_d       = wptr_q;
    cnt_d        = cnt_q;
    drop_d       = drop_q;
    enq_pkts_d   = enq_pkts_q;
    enq_bytes_d  = enq_bytes_q;
    sent_pkts_d  = sent_pkts_q;
    sent_bytes_d = sent_bytes_q;
    srv_d        = srv_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = {tgt, wptr_q[tgt]};
    out_d        = out_q;

    if (exec_commit && !miss && tgt_ok) begin
      if (op_enq) begin
        if (full) begin
          drop_d = drop_q + 32'd1;
        end else begin
          mem_we      = 1'b1;
          wptr_d[tgt] = (wptr_q[tgt] == PTR_LAST) ? '0 : wptr_q[tgt] + 1'b1;
          cnt_d[tgt]  = cnt_q[tgt] + 1'b1;
          enq_pkts_d  = enq_pkts_q + 32'd1;
          enq_bytes_d = enq_bytes_q + 48'(req_q.pkt_len);
        end
      end else if (do_pop) begin
        mem_re      = 1'b1;
        mem_addr    = {tgt, rptr_q[tgt]};
        rptr_d[tgt] = (rptr_q[tgt] == PTR_LAST) ? '0 : rptr_q[tgt] + 1'b1;
        cnt_d[tgt]  = cnt_q[tgt] - 1'b1;
        srv_d       = tgt4[2:0];
      end
    end

    if (read_load) begin
      sent_pkts_d  = sent_pkts_q + 32'd1;
      sent_bytes_d = sent_bytes_q + 48'(rd_q.len);
    end

    if (exec_load || read_load) begin
      out_d.out_handle   = '0;
      out_d.out_len      = '0;
      out_d.served_class = '0;
      if (read_load) begin
        out_d.status       = STAT_OK;
        out_d.out_handle   = rd_q.handle;
        out_d.out_len      = rd_q.len;
        out_d.served_class = srv_q;
      end else if (miss) begin
        out_d.status = STAT_EMPTY;
      end else if (!tgt_ok) begin
        out_d.status = STAT_BADCLASS;
      end else if (op_enq) begin
        out_d.status       = full ? STAT_FULL : STAT_OK;
        out_d.served_class = tgt4[2:0];
      end else begin
        out_d.status       = STAT_EMPTY;
        out_d.served_class = tgt4[2:0];
      end
      out_d.dropped_total        = drop_d;
      out_d.queued_packets_total = enq_pkts_d;
      out_d.queued_bytes_total   = enq_bytes_d;
      out_d.sent_packets_total   = sent_pkts_d;
      out_d.sent_bytes_total     = sent_bytes_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= '{handle: req_q.pkt_handle, len: req_q.pkt_len};
    end
    if (mem_re) begin
      rd_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_word_i;
    end
    srv_q <= srv_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mode_q       <= '0;
      dflt_q       <= '0;
      drop_q       <= '0;
      enq_pkts_q   <= '0;
      enq_bytes_q  <= '0;
      sent_pkts_q  <= '0;
      sent_bytes_q <= '0;
      out_valid_q  <= 1'b0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        rptr_q[k] <= '0;
        wptr_q[k] <= '0;
        cnt_q[k]  <= '0;
      end
    end else begin
      state_q      <= state_d;
      drop_q       <= drop_d;
      enq_pkts_q   <= enq_pkts_d;
      enq_bytes_q  <= enq_bytes_d;
      sent_pkts_q  <= sent_pkts_d;
      sent_bytes_q <= sent_bytes_d;
      rptr_q       <= rptr_d;
      wptr_q       <= wptr_d;
      cnt_q        <= cnt_d;
      if (exec_load || read_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SCHED_MODE:    mode_q <= cfg_data_i[1:0];
          CFG_DEFAULT_CLASS: dflt_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
